[design/gble_pkg.sv]
// ----------------------------------------------------------------------------
// gble_pkg
// shared types, codes and constants of the gap buffer line editor
// ----------------------------------------------------------------------------
package gble_pkg;

    localparam int BUF_DEPTH_DEF = 4096;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 12;
    localparam int STAT_W = 13;

    // command field
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // terminal bytes
    localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_ESC   = 8'd27;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] CH_THREE = 8'h33;
    localparam logic [BYTE_W-1:0] CH_FOUR  = 8'h34;
    localparam logic [BYTE_W-1:0] CH_UP    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_DOWN  = 8'h42;
    localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h43;
    localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h44;
    localparam logic [BYTE_W-1:0] CH_LBR   = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_RUB   = 8'd127;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INS,
        OP_NL,
        OP_BKSP,
        OP_DEL,
        OP_HOME,
        OP_END,
        OP_UP,
        OP_DOWN,
        OP_RIGHT,
        OP_LEFT,
        OP_READ
    } t_op_code;

    typedef struct packed {
        t_op_code              code;
        logic [BYTE_W-1:0]     data;
        logic [IDX_W-1:0]      idx;
    } t_op;

    typedef struct packed {
        logic [BYTE_W-1:0] read_char;
        logic              read_valid;
        logic [STAT_W-1:0] cursor_column;
        logic [STAT_W-1:0] line_number;
        logic [STAT_W-1:0] line_offset;
        logic [STAT_W-1:0] text_length;
        logic              buffer_full;
    } t_result;

endpackage

[design/gble_if.sv]
// ----------------------------------------------------------------------------
// gble_in_if / gble_out_if
// valid/ready channels of the line editor
// ----------------------------------------------------------------------------
interface gble_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [gble_pkg::BYTE_W-1:0]  byte_in;
    logic [gble_pkg::IDX_W-1:0]   read_index;

    modport source (output valid, command, byte_in, read_index, input ready);
    modport sink   (input valid, command, byte_in, read_index, output ready);
endinterface

interface gble_out_if;
    logic                         valid;
    logic                         ready;
    logic [gble_pkg::BYTE_W-1:0]  read_char;
    logic                         read_valid;
    logic [gble_pkg::STAT_W-1:0]  cursor_column;
    logic [gble_pkg::STAT_W-1:0]  line_number;
    logic [gble_pkg::STAT_W-1:0]  line_offset;
    logic [gble_pkg::STAT_W-1:0]  text_length;
    logic                         buffer_full;

    modport source (output valid, read_char, read_valid, cursor_column, line_number,
                    line_offset, text_length, buffer_full, input ready);
    modport sink   (input valid, read_char, read_valid, cursor_column, line_number,
                    line_offset, text_length, buffer_full, output ready);
endinterface

[design/gble_ram.sv]
// ----------------------------------------------------------------------------
// gble_ram
// generic single write, single registered read memory
// ----------------------------------------------------------------------------
module gble_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/gble_front.sv]
// ----------------------------------------------------------------------------
// gble_front
// accepts beats, decodes escape sequences into editor operations
// ----------------------------------------------------------------------------
module gble_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gble_in_if.sink         i_item,
    input  logic            i_q_full,
    output logic            o_push,
    output gble_pkg::t_op   o_op
);
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ESC   = 2'd1;
    localparam logic [1:0] PH_CSI   = 2'd2;
    localparam logic [1:0] PH_DIGIT = 2'd3;

    localparam logic [1:0] DG_HOME = 2'd1;
    localparam logic [1:0] DG_DEL  = 2'd2;
    localparam logic [1:0] DG_END  = 2'd3;

    logic [1:0]    r_phase;
    logic [1:0]    r_digit;
    logic [1:0]    n_phase;
    logic [1:0]    n_digit;
    gble_pkg::t_op n_op;
    logic [7:0]    b;

    assign b = i_item.byte_in;
    assign i_item.ready = !i_q_full;
    assign o_push = i_item.valid && !i_q_full;
    assign o_op = n_op;

    always_comb begin
        n_phase   = r_phase;
        n_digit   = r_digit;
        n_op.code = gble_pkg::OP_NOP;
        n_op.data = b;
        n_op.idx  = i_item.read_index;
        if (i_item.command == gble_pkg::CMD_READ) begin
            n_op.code = gble_pkg::OP_READ;
        end else begin
            unique case (r_phase)
                PH_ESC: begin
                    n_phase = (b == gble_pkg::CH_LBR) ? PH_CSI : PH_IDLE;
                end
                PH_CSI: begin
                    n_phase = PH_IDLE;
                    if (b == gble_pkg::CH_UP) begin
                        n_op.code = gble_pkg::OP_UP;
                    end else if (b == gble_pkg::CH_DOWN) begin
                        n_op.code = gble_pkg::OP_DOWN;
                    end else if (b == gble_pkg::CH_RIGHT) begin
                        n_op.code = gble_pkg::OP_RIGHT;
                    end else if (b == gble_pkg::CH_LEFT) begin
                        n_op.code = gble_pkg::OP_LEFT;
                    end else if (b == gble_pkg::CH_ONE) begin
                        n_digit = DG_HOME;
                        n_phase = PH_DIGIT;
                    end else if (b == gble_pkg::CH_THREE) begin
                        n_digit = DG_DEL;
                        n_phase = PH_DIGIT;
                    end else if (b == gble_pkg::CH_FOUR) begin
                        n_digit = DG_END;
                        n_phase = PH_DIGIT;
                    end
                end
                PH_DIGIT: begin
                    n_phase = PH_IDLE;
                    if (b == gble_pkg::CH_TILDE) begin
                        if (r_digit == DG_HOME) begin
                            n_op.code = gble_pkg::OP_HOME;
                        end else if (r_digit == DG_DEL) begin
                            n_op.code = gble_pkg::OP_DEL;
                        end else if (r_digit == DG_END) begin
                            n_op.code = gble_pkg::OP_END;
                        end
                    end
                end
                default: begin
                    if (b == gble_pkg::CH_ESC) begin
                        n_phase = PH_ESC;
                    end else if (b == gble_pkg::CH_BS || b == gble_pkg::CH_RUB) begin
                        n_op.code = gble_pkg::OP_BKSP;
                    end else if (b == gble_pkg::CH_CR) begin
                        n_op.code = gble_pkg::OP_NL;
                        n_op.data = gble_pkg::CH_NL;
                    end else if (b >= gble_pkg::CH_SPACE && b < gble_pkg::CH_RUB) begin
                        n_op.code = gble_pkg::OP_INS;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_digit <= 2'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_digit <= n_digit;
        end
    end
endmodule

[design/gble_queue.sv]
// ----------------------------------------------------------------------------
// gble_queue
// two-entry operation queue between front and back
// ----------------------------------------------------------------------------
module gble_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gble_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output gble_pkg::t_op o_op
);
    gble_pkg::t_op r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_op;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule

[design/gble_back.sv]
// ----------------------------------------------------------------------------
// gble_back
// gap buffer sequencer: moves, scans and edits over the text memory
// ----------------------------------------------------------------------------
module gble_back #(
    parameter int BUF_DEPTH = gble_pkg::BUF_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  gble_pkg::t_op i_q_op,
    output logic          o_pop,
    gble_out_if.source    o_result
);
    localparam int AW = $clog2(BUF_DEPTH);
    localparam int PW = $clog2(BUF_DEPTH + 1);
    localparam int CW = (PW > gble_pkg::IDX_W) ? PW : gble_pkg::IDX_W;
    localparam logic [PW-1:0] DEPTH_P = PW'(BUF_DEPTH);
    localparam logic [PW-1:0] ONE     = PW'(1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RDW   = 3'd1;
    localparam logic [2:0] ST_MOVE  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_PUT   = 3'd4;
    localparam logic [2:0] ST_CLAMP = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]        r_state;
    gble_pkg::t_op     r_op;
    logic [PW-1:0]     r_gs, r_ge, r_lb, r_cur, r_lc, r_col;
    logic              r_join;
    logic [PW-1:0]     r_src, r_dst, r_cnt, r_wa;
    logic              r_down, r_wv;
    logic [PW-1:0]     r_ptr, r_chk_p, r_found;
    logic              r_chk_v, r_sback;
    logic [7:0]        r_rc;
    logic              r_rv;
    gble_pkg::t_result r_res;
    logic              r_res_v;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    logic [PW-1:0]     len, idx_p, rd_addr, s_res;
    logic              in_range, full, s_hit, s_done, load;

    gble_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign len      = r_gs + (DEPTH_P - r_ge);
    assign full     = (r_gs == r_ge);
    assign idx_p    = PW'(i_q_op.idx);
    assign in_range = CW'(i_q_op.idx) < CW'(len);
    assign rd_addr  = (CW'(i_q_op.idx) < CW'(r_gs)) ? idx_p : r_ge + idx_p - r_gs;

    assign s_hit  = r_chk_v && (ram_rdata == gble_pkg::CH_NL);
    assign s_done = s_hit || (r_sback ? (r_ptr == '0) : (r_ptr == DEPTH_P));
    assign s_res  = s_hit ? r_chk_p : r_ptr;

    assign o_pop = (r_state == ST_IDLE) && i_q_valid;
    assign load  = (r_state == ST_DONE) && (!r_res_v || o_result.ready);

    always_comb begin
        logic [PW-1:0] ra;
        ra = r_src;
        unique case (r_state)
            ST_IDLE: ra = rd_addr;
            ST_SCAN: ra = r_sback ? r_ptr - ONE : r_ptr;
            default: ra = r_src;
        endcase
        ram_raddr = ra[AW-1:0];
        ram_we    = (r_state == ST_PUT) || ((r_state == ST_MOVE) && r_wv);
        ram_waddr = (r_state == ST_PUT) ? r_cur[AW-1:0] : r_wa[AW-1:0];
        ram_wdata = (r_state == ST_PUT) ? r_op.data : ram_rdata;
    end

    assign o_result.valid         = r_res_v;
    assign o_result.read_char     = r_res.read_char;
    assign o_result.read_valid    = r_res.read_valid;
    assign o_result.cursor_column = r_res.cursor_column;
    assign o_result.line_number   = r_res.line_number;
    assign o_result.line_offset   = r_res.line_offset;
    assign o_result.text_length   = r_res.text_length;
    assign o_result.buffer_full   = r_res.buffer_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_gs    <= '0;
            r_ge    <= DEPTH_P;
            r_lb    <= '0;
            r_cur   <= '0;
            r_lc    <= ONE;
            r_wv    <= 1'b0;
            r_chk_v <= 1'b0;
            r_res_v <= 1'b0;
        end else begin
            if (r_res_v && o_result.ready && !load) begin
                r_res_v <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_wv    <= 1'b0;
                    r_chk_v <= 1'b0;
                    r_rc    <= 8'd0;
                    r_rv    <= 1'b0;
                    if (i_q_valid) begin
                        r_op  <= i_q_op;
                        r_col <= r_cur - r_lb;
                        unique case (i_q_op.code)
                            gble_pkg::OP_READ: begin
                                r_state <= in_range ? ST_RDW : ST_DONE;
                            end
                            gble_pkg::OP_INS, gble_pkg::OP_NL: begin
                                // open a slot at the cursor
                                r_src   <= r_gs - ONE;
                                r_dst   <= r_gs;
                                r_cnt   <= r_gs - r_cur;
                                r_down  <= 1'b1;
                                r_state <= full ? ST_DONE : ST_MOVE;
                            end
                            gble_pkg::OP_BKSP: begin
                                r_down <= 1'b0;
                                if (r_cur > r_lb) begin
                                    r_cur   <= r_cur - ONE;
                                    r_src   <= r_cur;
                                    r_dst   <= r_cur - ONE;
                                    r_cnt   <= r_gs - r_cur;
                                    r_join  <= 1'b0;
                                    r_state <= ST_MOVE;
                                end else if (r_lb != '0) begin
                                    r_cur   <= r_lb - ONE;
                                    r_src   <= r_lb;
                                    r_dst   <= r_lb - ONE;
                                    r_cnt   <= r_gs - r_lb;
                                    r_join  <= 1'b1;
                                    r_state <= ST_MOVE;
                                end else begin
                                    r_state <= ST_DONE;
                                end
                            end
                            gble_pkg::OP_DEL: begin
                                r_down <= 1'b0;
                                if (r_cur < r_gs) begin
                                    r_src   <= r_cur + ONE;
                                    r_dst   <= r_cur;
                                    r_cnt   <= r_gs - r_cur - ONE;
                                    r_join  <= 1'b0;
                                    r_state <= ST_MOVE;
                                end else if (r_ge != DEPTH_P) begin
                                    r_join  <= 1'b1;
                                    r_ptr   <= r_ge + ONE;
                                    r_sback <= 1'b0;
                                    r_state <= ST_SCAN;
                                end else begin
                                    r_state <= ST_DONE;
                                end
                            end
                            gble_pkg::OP_HOME: begin
                                r_cur   <= r_lb;
                                r_state <= ST_DONE;
                            end
                            gble_pkg::OP_END: begin
                                r_cur   <= r_gs;
                                r_state <= ST_DONE;
                            end
                            gble_pkg::OP_UP: begin
                                r_ptr   <= r_lb - ONE;
                                r_sback <= 1'b1;
                                r_state <= (r_lb != '0) ? ST_SCAN : ST_CLAMP;
                            end
                            gble_pkg::OP_DOWN: begin
                                r_ptr   <= r_ge + ONE;
                                r_sback <= 1'b0;
                                r_state <= (r_ge != DEPTH_P) ? ST_SCAN : ST_CLAMP;
                            end
                            gble_pkg::OP_RIGHT: begin
                                r_ptr   <= r_ge + ONE;
                                r_sback <= 1'b0;
                                if (r_cur < r_gs) begin
                                    r_cur   <= r_cur + ONE;
                                    r_state <= ST_DONE;
                                end else if (r_ge != DEPTH_P) begin
                                    r_cur   <= r_cur + ONE;
                                    r_state <= ST_SCAN;
                                end else begin
                                    r_state <= ST_DONE;
                                end
                            end
                            gble_pkg::OP_LEFT: begin
                                r_ptr   <= r_lb - ONE;
                                r_sback <= 1'b1;
                                if (r_cur != '0) begin
                                    r_cur   <= r_cur - ONE;
                                    r_state <= (r_cur == r_lb) ? ST_SCAN : ST_DONE;
                                end else begin
                                    r_state <= ST_DONE;
                                end
                            end
                            default: r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_RDW: begin
                    r_rc    <= ram_rdata;
                    r_rv    <= 1'b1;
                    r_state <= ST_DONE;
                end
                ST_MOVE: begin
                    if (r_cnt != '0) begin
                        r_wv  <= 1'b1;
                        r_wa  <= r_dst;
                        r_src <= r_down ? r_src - ONE : r_src + ONE;
                        r_dst <= r_down ? r_dst - ONE : r_dst + ONE;
                        r_cnt <= r_cnt - ONE;
                    end else begin
                        r_wv <= 1'b0;
                        if (!r_wv) begin
                            unique case (r_op.code)
                                gble_pkg::OP_INS, gble_pkg::OP_NL: r_state <= ST_PUT;
                                gble_pkg::OP_BKSP: begin
                                    r_gs    <= r_gs - ONE;
                                    r_ptr   <= r_lb - ONE;
                                    r_sback <= 1'b1;
                                    r_chk_v <= 1'b0;
                                    r_state <= r_join ? ST_SCAN : ST_DONE;
                                end
                                gble_pkg::OP_DEL: begin
                                    if (r_join) begin
                                        r_gs <= r_gs + r_found - r_ge;
                                        r_ge <= r_found;
                                    end else begin
                                        r_gs <= r_gs - ONE;
                                    end
                                    r_state <= ST_DONE;
                                end
                                gble_pkg::OP_UP, gble_pkg::OP_LEFT: begin
                                    r_ge    <= r_ge - r_gs + r_lb - ONE;
                                    r_gs    <= r_lb - ONE;
                                    r_lb    <= r_found;
                                    r_lc    <= r_lc - ONE;
                                    r_state <= (r_op.code == gble_pkg::OP_UP) ? ST_CLAMP : ST_DONE;
                                end
                                default: begin
                                    r_gs    <= r_gs + r_found - r_ge;
                                    r_ge    <= r_found;
                                    r_lb    <= r_gs + ONE;
                                    r_lc    <= r_lc + ONE;
                                    r_state <= (r_op.code == gble_pkg::OP_DOWN) ? ST_CLAMP : ST_DONE;
                                end
                            endcase
                        end
                    end
                end
                ST_SCAN: begin
                    if (s_done) begin
                        r_chk_v <= 1'b0;
                        r_found <= s_res;
                        unique case (r_op.code)
                            gble_pkg::OP_BKSP: begin
                                r_lb    <= s_res;
                                r_lc    <= r_lc - ONE;
                                r_state <= ST_DONE;
                            end
                            gble_pkg::OP_UP, gble_pkg::OP_LEFT: begin
                                r_src   <= r_gs - ONE;
                                r_dst   <= r_ge - ONE;
                                r_cnt   <= r_gs - r_lb + ONE;
                                r_down  <= 1'b1;
                                r_state <= ST_MOVE;
                            end
                            gble_pkg::OP_DEL: begin
                                r_ge    <= r_ge + ONE;
                                r_src   <= r_ge + ONE;
                                r_dst   <= r_gs;
                                r_cnt   <= s_res - r_ge - ONE;
                                r_down  <= 1'b0;
                                r_state <= ST_MOVE;
                            end
                            default: begin
                                r_src   <= r_ge;
                                r_dst   <= r_gs;
                                r_cnt   <= s_res - r_ge;
                                r_down  <= 1'b0;
                                r_state <= ST_MOVE;
                            end
                        endcase
                    end else begin
                        r_chk_v <= 1'b1;
                        r_chk_p <= r_ptr;
                        r_ptr   <= r_sback ? r_ptr - ONE : r_ptr + ONE;
                    end
                end
                ST_PUT: begin
                    r_gs  <= r_gs + ONE;
                    r_cur <= r_cur + ONE;
                    if (r_op.code == gble_pkg::OP_NL) begin
                        r_lb <= r_cur + ONE;
                        r_lc <= r_lc + ONE;
                    end
                    r_state <= ST_DONE;
                end
                ST_CLAMP: begin
                    r_cur   <= (r_col > r_gs - r_lb) ? r_gs : r_lb + r_col;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (load) begin
                        r_res_v <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res.read_char     <= r_rc;
            r_res.read_valid    <= r_rv;
            r_res.cursor_column <= gble_pkg::STAT_W'(r_cur - r_lb);
            r_res.line_number   <= gble_pkg::STAT_W'(r_lc);
            r_res.line_offset   <= gble_pkg::STAT_W'(r_lb);
            r_res.text_length   <= gble_pkg::STAT_W'(len);
            r_res.buffer_full   <= full;
        end
    end
endmodule

[design/gap_buffer_line_editor_unit.sv]
// ----------------------------------------------------------------------------
// gap_buffer_line_editor_unit
// terminal line editor holding its text in a gap buffer
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  i_item     in   valid/ready    command, byte_in, read_index
//  o_result   out  valid/ready    read_char, read_valid, cursor_column,
//                                 line_number, line_offset, text_length,
//                                 buffer_full
//
//  a beat may move or scan bytes in the text memory, one byte at a time
//  through its single port pair, and the back takes no new beat until
//  that edit and its result are done
//  reset is synchronous and active low; the text memory is not cleared
//  the front keeps taking beats while the two-entry queue has room; a
//  finished result waits in an output register while the back takes the
//  next beat, and the back holds in its last state only while that register
//  is still occupied
// ----------------------------------------------------------------------------
module gap_buffer_line_editor_unit #(
    parameter int BUF_DEPTH = gble_pkg::BUF_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gble_in_if.sink    i_item,
    gble_out_if.source o_result
);
    // front to queue
    logic          push;
    logic          q_full;
    gble_pkg::t_op f_op;

    // queue to back
    logic          pop;
    logic          q_valid;
    gble_pkg::t_op q_op;

    // escape decoding and classification
    gble_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_push   (push),
        .o_op     (f_op)
    );

    // decouples the byte stream from long edits
    gble_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (f_op),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    // gap buffer edits and result register
    gble_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_op    (q_op),
        .o_pop     (pop),
        .o_result  (o_result)
    );
endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// regression for the gap buffer line editor: directed keystroke and escape
// sequence cases, then random typing and reads under varied flow control,
// every result checked against an in-bench model of the editor
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 4096;
    localparam int TAIL_CYCLES = 3 * DEPTH;

    logic i_clk;
    logic i_rst_n;

    gble_in_if  item_ch ();
    gble_out_if result_ch ();

    gap_buffer_line_editor_unit #(.BUF_DEPTH(DEPTH)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch.sink),
        .o_result (result_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // editor model: text store, gap pointers, line tracking, escape state
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {ESC_IDLE, ESC_SEEN, ESC_BRACKET, ESC_DIGIT} t_esc_phase;
    typedef enum logic [1:0] {DIG_NONE, DIG_HOME, DIG_DEL, DIG_END} t_esc_digit;

    logic [7:0]  ed_text [DEPTH];
    int unsigned ed_gap_lo, ed_gap_hi, ed_line_start, ed_cursor, ed_line_no;
    t_esc_phase  ed_phase;
    t_esc_digit  ed_digit;

    gble_pkg::t_result expected_results [$];
    bit      failed;
    int      ready_stall_pct;
    int      send_idle_pct;
    bit      hold_receiver;

    function automatic logic [7:0] text_at(int unsigned i);
        return (i < DEPTH) ? ed_text[i] : 8'd0;
    endfunction

    function automatic void text_put(int unsigned i, logic [7:0] v);
        if (i < DEPTH) ed_text[i] = v;
    endfunction

    function automatic int unsigned text_len();
        return ed_gap_lo + DEPTH - ed_gap_hi;
    endfunction

    // move the gap left so it starts at new_lo
    function automatic void gap_left(int unsigned new_lo);
        int unsigned n;
        n = ed_gap_lo - new_lo;
        ed_gap_lo = new_lo;
        ed_gap_hi -= n;
        for (int unsigned i = n; i > 0; i--)
            text_put(ed_gap_hi + i - 1, text_at(ed_gap_lo + i - 1));
    endfunction

    // move the gap right so it ends at new_hi
    function automatic void gap_right(int unsigned new_hi);
        int unsigned n;
        n = new_hi - ed_gap_hi;
        for (int unsigned i = 0; i < n; i++)
            text_put(ed_gap_lo + i, text_at(ed_gap_hi + i));
        ed_gap_hi = new_hi;
        ed_gap_lo += n;
    endfunction

    function automatic void insert_char(logic [7:0] c);
        if (ed_gap_lo == ed_gap_hi) return;
        for (int unsigned i = ed_gap_lo; i > ed_cursor; i--)
            text_put(i, text_at(i - 1));
        text_put(ed_cursor, c);
        ed_gap_lo++;
        ed_cursor++;
    endfunction

    function automatic void remove_at_cursor();
        if (ed_cursor >= ed_gap_lo) return;
        for (int unsigned i = ed_cursor; i + 1 < ed_gap_lo; i++)
            text_put(i, text_at(i + 1));
        ed_gap_lo--;
    endfunction

    function automatic void go_prev_line();
        int unsigned p;
        if (ed_line_start == 0) return;
        p = ed_line_start - 1;
        while (p > 0 && text_at(p - 1) != gble_pkg::CH_NL) p--;
        gap_left(ed_line_start - 1);
        ed_line_start = p;
        ed_line_no--;
    endfunction

    function automatic void go_next_line();
        int unsigned n, old_lo;
        if (ed_gap_hi >= DEPTH) return;
        n = ed_gap_hi + 1;
        while (n < DEPTH && text_at(n) != gble_pkg::CH_NL) n++;
        old_lo = ed_gap_lo;
        gap_right(n);
        ed_line_start = old_lo + 1;
        ed_line_no++;
    endfunction

    function automatic void fit_column(int unsigned col);
        if (col > ed_gap_lo - ed_line_start) ed_cursor = ed_gap_lo;
        else ed_cursor = ed_line_start + col;
    endfunction

    function automatic void apply_arrow(logic [7:0] b);
        int unsigned col;
        col = ed_cursor - ed_line_start;
        case (b)
            gble_pkg::CH_UP: begin
                go_prev_line();
                fit_column(col);
            end
            gble_pkg::CH_DOWN: begin
                go_next_line();
                fit_column(col);
            end
            gble_pkg::CH_RIGHT: begin
                if (ed_cursor < ed_gap_lo || ed_gap_hi < DEPTH) begin
                    ed_cursor++;
                    if (ed_cursor > ed_gap_lo) go_next_line();
                end
            end
            default: begin
                if (ed_cursor > 0) begin
                    ed_cursor--;
                    if (ed_cursor < ed_line_start) go_prev_line();
                end
            end
        endcase
    endfunction

    function automatic void apply_backspace();
        if (ed_cursor > ed_line_start) begin
            ed_cursor--;
            remove_at_cursor();
        end else if (ed_line_start > 0) begin
            // join with the previous line
            ed_cursor = ed_line_start - 1;
            remove_at_cursor();
            do ed_line_start--;
            while (ed_line_start > 0 && text_at(ed_line_start - 1) != gble_pkg::CH_NL);
            ed_line_no--;
        end
    endfunction

    function automatic void apply_delete();
        int unsigned e;
        if (ed_cursor < ed_gap_lo) begin
            remove_at_cursor();
        end else if (ed_gap_hi < DEPTH) begin
            // pull the next line up behind the gap
            ed_gap_hi++;
            e = ed_gap_hi;
            while (e < DEPTH && text_at(e) != gble_pkg::CH_NL) e++;
            gap_right(e);
        end
    endfunction

    function automatic void apply_key(logic [7:0] b);
        case (ed_phase)
            ESC_SEEN: begin
                ed_phase = (b == gble_pkg::CH_LBR) ? ESC_BRACKET : ESC_IDLE;
                return;
            end
            ESC_BRACKET: begin
                ed_phase = ESC_IDLE;
                if (b >= gble_pkg::CH_UP && b <= gble_pkg::CH_LEFT) begin
                    apply_arrow(b);
                end else if (b == gble_pkg::CH_ONE || b == gble_pkg::CH_THREE ||
                             b == gble_pkg::CH_FOUR) begin
                    ed_digit = (b == gble_pkg::CH_ONE) ? DIG_HOME :
                               (b == gble_pkg::CH_THREE) ? DIG_DEL : DIG_END;
                    ed_phase = ESC_DIGIT;
                end
                return;
            end
            ESC_DIGIT: begin
                ed_phase = ESC_IDLE;
                if (b == gble_pkg::CH_TILDE) begin
                    if (ed_digit == DIG_HOME) ed_cursor = ed_line_start;
                    else if (ed_digit == DIG_DEL) apply_delete();
                    else if (ed_digit == DIG_END) ed_cursor = ed_gap_lo;
                end
                return;
            end
            default: ;
        endcase
        if (b == gble_pkg::CH_ESC) ed_phase = ESC_SEEN;
        else if (b == gble_pkg::CH_BS || b == gble_pkg::CH_RUB) apply_backspace();
        else if (b == gble_pkg::CH_CR) begin
            if (ed_gap_lo != ed_gap_hi) begin
                insert_char(gble_pkg::CH_NL);
                ed_line_start = ed_cursor;
                ed_line_no++;
            end
        end else if (b >= gble_pkg::CH_SPACE && b < gble_pkg::CH_RUB) insert_char(b);
    endfunction

    function automatic gble_pkg::t_result editor_outcome(logic cmd, logic [7:0] b,
                                                         logic [11:0] idx);
        gble_pkg::t_result r;
        int unsigned n;
        r = '0;
        if (cmd == gble_pkg::CMD_READ) begin
            n = text_len();
            if (idx < n) begin
                r.read_valid = 1'b1;
                r.read_char = (idx < ed_gap_lo) ? text_at(idx) :
                              text_at(ed_gap_hi + (idx - ed_gap_lo));
            end
        end else begin
            apply_key(b);
        end
        r.cursor_column = 13'(ed_cursor - ed_line_start);
        r.line_number   = 13'(ed_line_no);
        r.line_offset   = 13'(ed_line_start);
        r.text_length   = 13'(text_len());
        r.buffer_full   = (ed_gap_lo == ed_gap_hi);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender: one beat, with a random idle gap first
    // ------------------------------------------------------------------
    task automatic send_beat(logic cmd, logic [7:0] b, logic [11:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.command    <= cmd;
        item_ch.byte_in    <= b;
        item_ch.read_index <= idx;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        // beat accepted at this edge
        expected_results.push_back(editor_outcome(cmd, b, idx));
    endtask

    // drop valid and wait for a clock edge
    task automatic sender_idle();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic key(logic [7:0] b);
        send_beat(gble_pkg::CMD_KEY, b, 12'($urandom));
    endtask

    task automatic read_at(logic [11:0] idx);
        send_beat(gble_pkg::CMD_READ, 8'($urandom), idx);
    endtask

    task automatic escape_seq(logic [7:0] b1, logic [7:0] b2);
        key(gble_pkg::CH_ESC);
        key(gble_pkg::CH_LBR);
        key(b1);
        if (b2 != 8'd0) key(b2);
    endtask

    task automatic drain();
        sender_idle();
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, or a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) result_ch.ready <= 1'b0;
        else if (hold_receiver) result_ch.ready <= 1'b0;
        else result_ch.ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        gble_pkg::t_result got, want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.read_char     = result_ch.read_char;
            got.read_valid    = result_ch.read_valid;
            got.cursor_column = result_ch.cursor_column;
            got.line_number   = result_ch.line_number;
            got.line_offset   = result_ch.line_offset;
            got.text_length   = result_ch.text_length;
            got.buffer_full   = result_ch.buffer_full;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, got);
                failed = 1'b1;
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                    failed = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        ready_stall_pct = 0;
        send_idle_pct = 0;
        read_at(12'd0);                                   // read of empty text
        key(gble_pkg::CH_BS);                             // backspace at start of text
        escape_seq(gble_pkg::CH_LEFT, 8'd0);              // left at text start
        escape_seq(gble_pkg::CH_UP, 8'd0);                // up on first line
        key(8'h20);
        key(8'h7E);
        key(gble_pkg::CH_CR);
        key(8'h41);
        key(8'h42);
        escape_seq(gble_pkg::CH_ONE, gble_pkg::CH_TILDE);   // home
        escape_seq(gble_pkg::CH_RIGHT, 8'd0);
        escape_seq(gble_pkg::CH_FOUR, gble_pkg::CH_TILDE);  // end
        escape_seq(gble_pkg::CH_UP, 8'd0);
        escape_seq(gble_pkg::CH_DOWN, 8'd0);
        escape_seq(gble_pkg::CH_THREE, gble_pkg::CH_TILDE); // delete
        key(gble_pkg::CH_RUB);
        read_at(12'd1);
        read_at(12'hFFF);
        key(gble_pkg::CH_ESC);                            // broken: ESC then ESC
        key(gble_pkg::CH_ESC);
        key(8'hFF);                                       // ignored byte
        key(8'h00);
    endtask

    // long hold-off fills the block; then pause until everything has come back
    task automatic test_backpressure();
        send_idle_pct = 0;
        ready_stall_pct = 0;
        fork
            begin
                hold_receiver = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_receiver = 1'b0;
            end
            begin
                repeat (12) key(8'($urandom_range(32, 126)));
                sender_idle();
            end
        join
        drain();
    endtask

    task automatic random_beat();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45) key(8'($urandom_range(32, 126)));
        else if (sel < 52) key(gble_pkg::CH_CR);
        else if (sel < 58) key(($urandom_range(1)) ? gble_pkg::CH_BS : gble_pkg::CH_RUB);
        else if (sel < 72)
            escape_seq(8'($urandom_range(gble_pkg::CH_UP, gble_pkg::CH_LEFT)), 8'd0);
        else if (sel < 80) begin
            case ($urandom_range(2))
                0: escape_seq(gble_pkg::CH_ONE, gble_pkg::CH_TILDE);
                1: escape_seq(gble_pkg::CH_THREE, gble_pkg::CH_TILDE);
                default: escape_seq(gble_pkg::CH_FOUR, gble_pkg::CH_TILDE);
            endcase
        end else if (sel < 92) read_at(12'($urandom_range(0, text_len() + 2)));
        else if (sel < 95) read_at(12'($urandom));
        else key(8'($urandom));         // noise, possibly broken sequences
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int beats);
        send_idle_pct = idle_pct;
        ready_stall_pct = stall_pct;
        repeat (beats) random_beat();
        drain();
    endtask

    initial begin
        failed = 1'b0;
        hold_receiver = 1'b0;
        ready_stall_pct = 0;
        send_idle_pct = 0;
        ed_gap_lo = 0;
        ed_gap_hi = DEPTH;
        ed_line_start = 0;
        ed_cursor = 0;
        ed_line_no = 1;
        ed_phase = ESC_IDLE;
        ed_digit = DIG_NONE;
        foreach (ed_text[i]) ed_text[i] = 8'd0;
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.command = gble_pkg::CMD_KEY;
        item_ch.byte_in = '0;
        item_ch.read_index = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random_phase(0, 0, 15);
        test_random_phase(87, 0, 14);
        test_random_phase(0, 87, 14);
        test_random_phase(17, 17, 14);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (!failed && expected_results.size() == 0)
            $display("gap_buffer_line_editor_unit regression: pass");
        else
            $display("gap_buffer_line_editor_unit regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #200ms;
        $display("gap_buffer_line_editor_unit regression: fail");
        $finish;
    end
endmodule
